[rtl/u8u16_pkg.sv]
package u8u16_pkg;

    // Status codes carried in the result item.
    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_ERROR      = 2'd2;

    // Lead byte classes: low nibble is the sequence length (zero means illegal),
    // high nibble is the match mask for the second byte.
    localparam logic [7:0] LC_ASCII     = 8'h01;
    localparam logic [7:0] LC_CONT_8X   = 8'h90;
    localparam logic [7:0] LC_CONT_9X   = 8'hA0;
    localparam logic [7:0] LC_CONT_AB   = 8'hC0;
    localparam logic [7:0] LC_ILLEGAL   = 8'h00;
    localparam logic [7:0] LC_LEAD2     = 8'h72;
    localparam logic [7:0] LC_LEAD3_E0  = 8'h43;
    localparam logic [7:0] LC_LEAD3_ED  = 8'h33;
    localparam logic [7:0] LC_LEAD3     = 8'h73;
    localparam logic [7:0] LC_LEAD4_F0  = 8'h64;
    localparam logic [7:0] LC_LEAD4     = 8'h74;
    localparam logic [7:0] LC_LEAD4_F4  = 8'h14;

    // Mask values written on errors, at the start of a sequence and for later continuation bytes.
    localparam logic [7:0] EM_LEAD_FLAG  = 8'h80;
    localparam logic [7:0] EM_LATER_CONT = 8'hF0;
    localparam logic [7:0] EM_BAD_LEAD   = 8'h01;
    localparam logic [7:0] EM_BAD_FOURTH = 8'h04;
    localparam logic [7:0] EM_NONE       = 8'h00;

    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

    function automatic logic [7:0] lead_code(input logic [7:0] b);
        logic [7:0] code;
        if (b < 8'h80)       code = LC_ASCII;
        else if (b < 8'h90)  code = LC_CONT_8X;
        else if (b < 8'hA0)  code = LC_CONT_9X;
        else if (b < 8'hC0)  code = LC_CONT_AB;
        else if (b < 8'hC2)  code = LC_ILLEGAL;
        else if (b < 8'hE0)  code = LC_LEAD2;
        else if (b == 8'hE0) code = LC_LEAD3_E0;
        else if (b == 8'hED) code = LC_LEAD3_ED;
        else if (b < 8'hF0)  code = LC_LEAD3;
        else if (b == 8'hF0) code = LC_LEAD4_F0;
        else if (b < 8'hF4)  code = LC_LEAD4;
        else if (b == 8'hF4) code = LC_LEAD4_F4;
        else                 code = LC_ILLEGAL;
        return code;
    endfunction

endpackage

[rtl/utf8_to_utf16_decoder.sv]
// The input register holds each accepted byte; the result register holds its decoded
// item and drives m_tvalid. Throughput: one byte per cycle unless m_tready stalls the
// output; the decode sits between the input register and the result register, and the
// sequence state updates as each result is loaded.
// Reset: aresetn is synchronous and active low; it empties both registers and returns
// the decoder to the start of a sequence. The saved sequence bytes are not reset.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] clear_state, [15:9] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [1:0] status, [4:2] seq_length, [25:5] code_point,
                                   // [41:26] utf16_first, [57:42] utf16_second,
                                   // [58] is_pair, [59] byte_used, [60] mid_sequence,
                                   // [63:61] zero
);

    // Input register stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_clear_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic [60:0] out_data_reg;

    // Sequence state: bytes taken so far, the continuation match mask, and the
    // bytes held until the character completes.
    logic [1:0]  position_reg, position_next;
    logic [7:0]  expect_mask_reg, expect_mask_next;
    logic [7:0]  saved_reg [3];
    logic [7:0]  saved_next [3];

    logic        out_load;

    // Decode results for the byte in the input register.
    logic [1:0]  pos_cur;
    logic [7:0]  lead_m;
    logic [3:0]  seq_n;
    logic [7:0]  match;
    logic [1:0]  status;
    logic [2:0]  seq_len;
    logic [20:0] code;
    logic [20:0] offset;
    logic [15:0] first_unit;
    logic [15:0] second_unit;
    logic        pair;
    logic        used;

    // The result register takes a new item when it is empty or its item is being
    // transferred out in this cycle; the input register follows it.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (out_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata[7:0];
            in_clear_reg <= s_tdata[8];
        end
    end

    // Byte decode. A clear request drops any open sequence before the byte is
    // looked at. At the start of a sequence the lead class picks ASCII, an
    // illegal byte, or the start of a multibyte run; inside a run the byte must
    // match the mask, otherwise the run is dropped and the byte is handed back.
    always_comb begin
        pos_cur          = in_clear_reg ? 2'd0 : position_reg;
        lead_m           = lead_code(in_byte_reg);
        match            = lead_m & expect_mask_reg;
        seq_n            = expect_mask_reg[3:0];
        position_next    = pos_cur;
        expect_mask_next = expect_mask_reg;
        saved_next       = saved_reg;
        status           = ST_INCOMPLETE;
        seq_len          = 3'd0;
        code             = 21'd0;
        first_unit       = 16'd0;
        second_unit      = 16'd0;
        pair             = 1'b0;
        used             = 1'b0;
        offset           = 21'd0;

        if (pos_cur == 2'd0) begin
            expect_mask_next = lead_m | EM_LEAD_FLAG;
            seq_n            = lead_m[3:0];
            if (seq_n == 4'd0) begin
                status           = ST_ERROR;
                used             = 1'b1;
                expect_mask_next = EM_BAD_LEAD;
            end else if (seq_n == 4'd1) begin
                status     = ST_COMPLETE;
                seq_len    = 3'd1;
                code       = {13'd0, in_byte_reg};
                first_unit = {8'd0, in_byte_reg};
            end else begin
                saved_next[0] = in_byte_reg;
                position_next = 2'd1;
            end
        end else if (match > EM_LEAD_FLAG) begin
            if (pos_cur == 2'd1) begin
                if (seq_n == 4'd2) begin
                    code          = {10'd0, saved_reg[0][4:0], in_byte_reg[5:0]};
                    status        = ST_COMPLETE;
                    seq_len       = 3'd2;
                    first_unit    = code[15:0];
                    position_next = 2'd0;
                end else begin
                    saved_next[1]    = in_byte_reg;
                    expect_mask_next = EM_LATER_CONT | {4'd0, seq_n};
                    position_next    = 2'd2;
                end
            end else if (pos_cur == 2'd2) begin
                if (seq_n == 4'd3) begin
                    code          = {5'd0, saved_reg[0][3:0], saved_reg[1][5:0],
                                     in_byte_reg[5:0]};
                    status        = ST_COMPLETE;
                    seq_len       = 3'd3;
                    first_unit    = code[15:0];
                    position_next = 2'd0;
                end else begin
                    saved_next[2] = in_byte_reg;
                    position_next = 2'd3;
                end
            end else begin
                if (seq_n == 4'd4) begin
                    code        = {saved_reg[0][2:0], saved_reg[1][5:0], saved_reg[2][5:0],
                                   in_byte_reg[5:0]};
                    offset      = code - SUPP_BASE;
                    first_unit  = HI_SURR_BASE + {6'd0, offset[19:10]};
                    second_unit = LO_SURR_BASE + {6'd0, offset[9:0]};
                    status      = ST_COMPLETE;
                    seq_len     = 3'd4;
                    pair        = 1'b1;
                end else begin
                    // A fourth byte without a four-byte lead; unreachable from the
                    // stream, answered as a consumed error.
                    status           = ST_ERROR;
                    used             = 1'b1;
                    expect_mask_next = EM_BAD_FOURTH;
                end
                position_next = 2'd0;
            end
        end else begin
            status           = ST_ERROR;
            expect_mask_next = EM_NONE;
            position_next    = 2'd0;
        end
    end

    // State advances only when the decoded item moves into the result register,
    // so a stalled output never lets a byte be decoded twice.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= 2'd0;
            expect_mask_reg <= 8'd0;
        end else if (out_load) begin
            position_reg    <= position_next;
            expect_mask_reg <= expect_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            saved_reg <= saved_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {(position_next != 2'd0), used, pair, second_unit, first_unit,
                             code, seq_len, status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

    // A shown result is self-consistent: a pair only for four-byte characters, an open
    // sequence only while the status is incomplete, a length only when it is complete.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[58] |-> out_data_reg[4:2] == 3'd4)
        else $error("surrogate pair without a four-byte length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[60] |-> out_data_reg[1:0] == ST_INCOMPLETE)
        else $error("open sequence reported with a final status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[1:0] != ST_COMPLETE |-> out_data_reg[4:2] == 3'd0)
        else $error("length reported without a completed character");

    // After a result that closes a sequence, the decoder is back at the start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && position_next == 2'd0 |=> position_reg == 2'd0)
        else $error("position not returned to start");

    // The result register is never overwritten while its item waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("waiting result lost");

endmodule
